[rtl/assert_macros.svh]
// assertion macros used by the rtl top file, cell_bin_overlap_unit
// no dependencies; pulled in by include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CBO_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cbo assertion failed");

// next-cycle implication, disabled while reset is asserted
`define CBO_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cbo assertion failed");

`endif

[rtl/cbo_pkg.sv]
// shared types and constants of the cell bin overlap unit
// no dependencies; used by every module of the block
package cbo_pkg;

  localparam int POS_W     = 50;  // signed position width, covers org + idx * bin size
  localparam int IDX_W     = 16;
  localparam int MAX_BINS  = 8;
  localparam int RUN_W     = $clog2(MAX_BINS);
  localparam int NSTAGE    = 9;   // stages of the per-axis pipeline
  localparam int EPS_SHIFT = 45;
  localparam logic [31:0] EPS_MUL   = 32'd3518437209;  // ceil(2^45 / 10000)
  localparam logic [31:0] EPS_ROUND = 32'd5000;
  localparam logic [30:0] OV_MAX    = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    REG_BIN_WIDTH  = 3'd0,
    REG_BIN_HEIGHT = 3'd1,
    REG_INV_WIDTH  = 3'd2,
    REG_INV_HEIGHT = 3'd3,
    REG_ORIGIN_X   = 3'd4,
    REG_ORIGIN_Y   = 3'd5,
    REG_BINS_X     = 3'd6,
    REG_BINS_Y     = 3'd7
  } cfg_idx_e;

  // one axis of a cell, ready for serialization
  typedef struct packed {
    logic signed [POS_W-1:0] lo;
    logic signed [POS_W-1:0] hi;
    logic signed [POS_W-1:0] bl;     // left edge of first bin
    logic signed [POS_W-1:0] br;     // right edge of first bin
    logic [IDX_W-1:0]        first;
    logic [RUN_W-1:0]        wm1;    // run length minus one
  } axis_res_t;

endpackage

[rtl/cbo_axis.sv]
// nine-stage pipeline that finds first bin, run length and extent on one axis
// depends on cbo_pkg
module cbo_axis (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [31:0]  center_i,
  input  logic signed [31:0]  size_i,
  input  logic [30:0]         bin_size_i,
  input  logic [31:0]         inv_i,
  input  logic signed [31:0]  origin_i,
  input  logic [15:0]         bins_i,
  output cbo_pkg::axis_res_t  res_o
);
  import cbo_pkg::*;

  logic [IDX_W-1:0]        nbm1;
  logic signed [POS_W-1:0] bw_s, org_s, c_s, s_s;

  assign nbm1  = (bins_i == 16'd0) ? 16'd0 : bins_i - 16'd1;
  assign bw_s  = {{(POS_W-31){1'b0}}, bin_size_i};
  assign org_s = {{(POS_W-32){origin_i[31]}}, origin_i};
  assign c_s   = {{(POS_W-32){center_i[31]}}, center_i};
  assign s_s   = {{(POS_W-32){size_i[31]}}, size_i};

  // stage registers
  logic signed [POS_W-1:0] lo1_q, hi1_q, lo2_q, hi2_q, dlo2_q, dhi2_q;
  logic signed [POS_W-1:0] lo3_q, hi3_q, hie3_q, lo4_q, hi4_q, hie4_q;
  logic signed [POS_W-1:0] lo5_q, hi5_q, hie5_q, lo6_q, hi6_q, hie6_q;
  logic signed [POS_W-1:0] lo7_q, hi7_q, hie7_q, lo8_q, hi8_q, lo9_q, hi9_q;
  logic [31:0]             epsn1_q;
  logic [63:0]             epsp2_q;
  logic                    nl3_q, nh3_q, nl4_q, nh4_q;
  logic [34:0]             ml3_q, mh3_q;
  logic [63:0]             pll4_q, phl4_q;
  logic [34:0]             plh4_q, phh4_q;
  logic [IDX_W-1:0]        il5_q, ir5_q, il6_q, ir6_q, il7_q, ir7_q;
  logic [46:0]             pl6_q, pr6_q;
  logic signed [POS_W-1:0] el7_q, elm7_q, elp7_q, er7_q, erp7_q;
  logic [IDX_W-1:0]        l8_q, l9_q;
  logic signed [IDX_W:0]   cr8_q;
  logic signed [POS_W-1:0] bl8_q, bl9_q, br9_q;
  logic [RUN_W-1:0]        wm19_q;

  // combinational helpers
  logic signed [POS_W-1:0] absl, absh, eps_s;
  logic [18:0]             epsq;
  logic [35:0]             rl, rh;
  logic [IDX_W-1:0]        il_d, ir_d, l_d, rr, diff;
  logic signed [IDX_W:0]   cr_d;
  logic signed [POS_W-1:0] bl_d;

  always_comb begin
    absl  = dlo2_q[POS_W-1] ? -dlo2_q : dlo2_q;
    absh  = dhi2_q[POS_W-1] ? -dhi2_q : dhi2_q;
    epsq  = epsp2_q[EPS_SHIFT +: 19];
    eps_s = (epsq == 19'd0) ? POS_W'(1) : {{(POS_W-19){1'b0}}, epsq};

    rl = {1'b0, plh4_q} + {4'd0, pll4_q[63:32]};
    rh = {1'b0, phh4_q} + {4'd0, phl4_q[63:32]};
    if (nl4_q) il_d = '0;
    else if (rl > {20'd0, nbm1}) il_d = nbm1;
    else il_d = rl[IDX_W-1:0];
    if (nh4_q) ir_d = '0;
    else if (rh > {20'd0, nbm1}) ir_d = nbm1;
    else ir_d = rh[IDX_W-1:0];

    // first bin: correct against exact edges, clamp to the grid
    if (el7_q > lo7_q) begin
      if (il7_q == '0) begin
        l_d  = '0;
        bl_d = el7_q;
      end else begin
        l_d  = il7_q - 16'd1;
        bl_d = elm7_q;
      end
    end else if (elp7_q <= lo7_q && il7_q != nbm1) begin
      l_d  = il7_q + 16'd1;
      bl_d = elp7_q;
    end else begin
      l_d  = il7_q;
      bl_d = el7_q;
    end

    // last bin, corrected at hi - eps
    if (er7_q > hie7_q) cr_d = $signed({1'b0, ir7_q}) - 17'sd1;
    else if (erp7_q <= hie7_q) cr_d = $signed({1'b0, ir7_q}) + 17'sd1;
    else cr_d = $signed({1'b0, ir7_q});

    if (cr8_q < $signed({1'b0, l8_q})) rr = l8_q;
    else if (cr8_q > $signed({1'b0, nbm1})) rr = nbm1;
    else rr = cr8_q[IDX_W-1:0];
    diff = rr - l8_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo1_q   <= c_s - (s_s >>> 1);
      hi1_q   <= c_s - (s_s >>> 1) + s_s;
      epsn1_q <= {1'b0, bin_size_i} + EPS_ROUND;

      lo2_q   <= lo1_q;
      hi2_q   <= hi1_q;
      dlo2_q  <= lo1_q - org_s;
      dhi2_q  <= hi1_q - org_s;
      epsp2_q <= epsn1_q * EPS_MUL;

      lo3_q  <= lo2_q;
      hi3_q  <= hi2_q;
      hie3_q <= hi2_q - eps_s;
      nl3_q  <= dlo2_q[POS_W-1];
      nh3_q  <= dhi2_q[POS_W-1];
      ml3_q  <= absl[34:0];
      mh3_q  <= absh[34:0];

      lo4_q  <= lo3_q;
      hi4_q  <= hi3_q;
      hie4_q <= hie3_q;
      nl4_q  <= nl3_q;
      nh4_q  <= nh3_q;
      pll4_q <= ml3_q[31:0] * inv_i;
      plh4_q <= ml3_q[34:32] * inv_i;
      phl4_q <= mh3_q[31:0] * inv_i;
      phh4_q <= mh3_q[34:32] * inv_i;

      lo5_q  <= lo4_q;
      hi5_q  <= hi4_q;
      hie5_q <= hie4_q;
      il5_q  <= il_d;
      ir5_q  <= ir_d;

      lo6_q  <= lo5_q;
      hi6_q  <= hi5_q;
      hie6_q <= hie5_q;
      il6_q  <= il5_q;
      ir6_q  <= ir5_q;
      pl6_q  <= il5_q * bin_size_i;
      pr6_q  <= ir5_q * bin_size_i;

      lo7_q  <= lo6_q;
      hi7_q  <= hi6_q;
      hie7_q <= hie6_q;
      il7_q  <= il6_q;
      ir7_q  <= ir6_q;
      el7_q  <= org_s + $signed({3'd0, pl6_q});
      elm7_q <= org_s + $signed({3'd0, pl6_q}) - bw_s;
      elp7_q <= org_s + $signed({3'd0, pl6_q}) + bw_s;
      er7_q  <= org_s + $signed({3'd0, pr6_q});
      erp7_q <= org_s + $signed({3'd0, pr6_q}) + bw_s;

      lo8_q <= lo7_q;
      hi8_q <= hi7_q;
      l8_q  <= l_d;
      bl8_q <= bl_d;
      cr8_q <= cr_d;

      lo9_q  <= lo8_q;
      hi9_q  <= hi8_q;
      l9_q   <= l8_q;
      bl9_q  <= bl8_q;
      br9_q  <= bl8_q + bw_s;
      wm19_q <= (diff > 16'(MAX_BINS - 1)) ? RUN_W'(MAX_BINS - 1) : diff[RUN_W-1:0];
    end
  end

  assign res_o.lo    = lo9_q;
  assign res_o.hi    = hi9_q;
  assign res_o.bl    = bl9_q;
  assign res_o.br    = br9_q;
  assign res_o.first = l9_q;
  assign res_o.wm1   = wm19_q;

endmodule

[rtl/cbo_emit.sv]
// serializer: turns one cell's x and y runs into result words, one per cycle unless out_stall_i holds it
// depends on cbo_pkg
module cbo_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  logic                item_skip_i,
  input  cbo_pkg::axis_res_t  res_x_i,
  input  cbo_pkg::axis_res_t  res_y_i,
  input  logic [30:0]         bw_x_i,
  input  logic [30:0]         bw_y_i,
  output logic                item_take_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                axis_o,
  output logic [2:0]          run_position_o,
  output logic [15:0]         bin_index_o,
  output logic [30:0]         overlap_o,
  output logic                last_result_o
);
  import cbo_pkg::*;

  logic                    job_q, ax_q, out_valid_q;
  logic [RUN_W-1:0]        j_q;
  axis_res_t               jx_q, jy_q, cur;
  logic signed [POS_W-1:0] bl_q, br_q, a, b, d, bw_cur;
  logic                    out_free, emit, step_end, done;
  logic [30:0]             ov;

  always_comb begin
    cur      = ax_q ? jy_q : jx_q;
    bw_cur   = {{(POS_W-31){1'b0}}, (ax_q ? bw_y_i : bw_x_i)};
    out_free = !out_valid_q || !out_stall_i;
    emit     = job_q && out_free;
    step_end = (j_q == cur.wm1);
    done     = emit && ax_q && step_end;
    a = (cur.lo > bl_q) ? cur.lo : bl_q;
    b = (cur.hi < br_q) ? cur.hi : br_q;
    d = b - a;
    if (d < 0) ov = '0;
    else if (d > $signed({{(POS_W-31){1'b0}}, OV_MAX})) ov = OV_MAX;
    else ov = d[30:0];
  end

  assign item_take_o = item_valid_i && (!job_q || done);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q       <= 1'b0;
      ax_q        <= 1'b0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (item_take_o) begin
        job_q <= !item_skip_i;
        ax_q  <= 1'b0;
        j_q   <= '0;
      end else if (emit) begin
        if (done) begin
          job_q <= 1'b0;
        end else if (step_end) begin
          ax_q <= 1'b1;
          j_q  <= '0;
        end else begin
          j_q <= j_q + RUN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      axis_o         <= ax_q;
      run_position_o <= 3'(j_q);
      bin_index_o    <= cur.first + {{(IDX_W-RUN_W){1'b0}}, j_q};
      overlap_o      <= ov;
      last_result_o  <= ax_q && step_end;
    end
    if (item_take_o) begin
      jx_q <= res_x_i;
      jy_q <= res_y_i;
      bl_q <= res_x_i.bl;
      br_q <= res_x_i.br;
    end else if (emit) begin
      if (step_end && !ax_q) begin
        bl_q <= jy_q.bl;
        br_q <= jy_q.br;
      end else begin
        bl_q <= br_q;
        br_q <= br_q + bw_cur;
      end
    end
  end

endmodule

[rtl/cell_bin_overlap_unit.sv]
// cell bin overlap unit: per-bin overlap lengths of a placement cell, x run then y run
// an accepted cell passes through the 9 pipeline stages, the serializer's job register,
//   then the output register before its first word is valid
// cells enter at one per cycle while the serializer keeps up; the serializer sends one word
//   per cycle unless out_stall_i holds it, wx + wy words (2..16) per cell, none for a skipped cell
// reset: rst_ni asynchronous active low; clears valid bits and loads register defaults
`include "assert_macros.svh"

module cell_bin_overlap_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_wdata_i,
  // cell words in
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] size_x_i,
  input  logic signed [31:0] size_y_i,
  // result words out
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               axis_o,
  output logic [2:0]         run_position_o,
  output logic [15:0]        bin_index_o,
  output logic [30:0]        overlap_o,
  output logic               last_result_o
);
  import cbo_pkg::*;

  // configuration registers
  logic [30:0]        bin_width_q, bin_height_q;
  logic [31:0]        inv_w_q, inv_h_q;
  logic signed [31:0] origin_x_q, origin_y_q;
  logic [15:0]        bins_x_q, bins_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_width_q  <= 31'd256000;
      bin_height_q <= 31'd256000;
      inv_w_q      <= 32'd16777;
      inv_h_q      <= 32'd16777;
      origin_x_q   <= '0;
      origin_y_q   <= '0;
      bins_x_q     <= 16'd512;
      bins_y_q     <= 16'd512;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_BIN_WIDTH:  bin_width_q  <= cfg_wdata_i[30:0];
        REG_BIN_HEIGHT: bin_height_q <= cfg_wdata_i[30:0];
        REG_INV_WIDTH:  inv_w_q      <= cfg_wdata_i;
        REG_INV_HEIGHT: inv_h_q      <= cfg_wdata_i;
        REG_ORIGIN_X:   origin_x_q   <= cfg_wdata_i;
        REG_ORIGIN_Y:   origin_y_q   <= cfg_wdata_i;
        REG_BINS_X:     bins_x_q     <= cfg_wdata_i[15:0];
        REG_BINS_Y:     bins_y_q     <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // valid and skip bits ride alongside the axis pipelines; the whole pipe
  // moves together and only holds when its last stage waits on the serializer
  logic [NSTAGE-1:0] v_q, skip_q;
  logic              adv, take, in_skip;
  axis_res_t         res_x, res_y;

  assign in_skip    = (size_x_i <= 32'sd0) || (size_y_i <= 32'sd0);
  assign adv        = !v_q[NSTAGE-1] || take;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      skip_q <= '0;
    end else if (adv) begin
      v_q    <= {v_q[NSTAGE-2:0], in_valid_i};
      skip_q <= {skip_q[NSTAGE-2:0], in_skip};
    end
  end

  // x and y run in parallel, same depth
  cbo_axis u_axis_x (
    .clk_i      (clk_i),
    .en_i       (adv),
    .center_i   (center_x_i),
    .size_i     (size_x_i),
    .bin_size_i (bin_width_q),
    .inv_i      (inv_w_q),
    .origin_i   (origin_x_q),
    .bins_i     (bins_x_q),
    .res_o      (res_x)
  );

  cbo_axis u_axis_y (
    .clk_i      (clk_i),
    .en_i       (adv),
    .center_i   (center_y_i),
    .size_i     (size_y_i),
    .bin_size_i (bin_height_q),
    .inv_i      (inv_h_q),
    .origin_i   (origin_y_q),
    .bins_i     (bins_y_q),
    .res_o      (res_y)
  );

  // serializer with output register, one result word per cycle while the receiver does not stall
  cbo_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (v_q[NSTAGE-1]),
    .item_skip_i    (skip_q[NSTAGE-1]),
    .res_x_i        (res_x),
    .res_y_i        (res_y),
    .bw_x_i         (bin_width_q),
    .bw_y_i         (bin_height_q),
    .item_take_o    (take),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .axis_o         (axis_o),
    .run_position_o (run_position_o),
    .bin_index_o    (bin_index_o),
    .overlap_o      (overlap_o),
    .last_result_o  (last_result_o)
  );

  // last marker only on a y word
  `CBO_ASSERT_IMP(a_last_on_y, clk_i, rst_ni, out_valid_o && last_result_o, axis_o)
  // an accepted cell shows up in the first stage
  `CBO_ASSERT_NXT(a_enter, clk_i, rst_ni, in_valid_i && !in_stall_o, v_q[0])
  // a cell waiting on the serializer is never dropped
  `CBO_ASSERT_NXT(a_hold, clk_i, rst_ni, v_q[NSTAGE-1] && !take, v_q[NSTAGE-1])

endmodule

[tb/sv/cell_bin_overlap_unit_tb.sv]
// testbench of the cell bin overlap unit: directed table then random cells, scoreboard check
// depends on cbo_pkg and cell_bin_overlap_unit
`timescale 1ns / 1ps

module cell_bin_overlap_unit_tb;
  import cbo_pkg::*;

  typedef struct {
    logic        axis;
    logic [2:0]  run_pos;
    logic [15:0] bin_idx;
    logic [30:0] overlap;
    logic        last;
  } overlap_word_t;

  typedef struct {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] sx;
    logic [31:0] sy;
    int          n_known;       // -1: word count not checked; else expected word count
  } cell_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic signed [31:0] center_x_i = '0, center_y_i = '0, size_x_i = '0, size_y_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        axis_o;
  logic [2:0]  run_position_o;
  logic [15:0] bin_index_o;
  logic [30:0] overlap_o;
  logic        last_result_o;

  cell_bin_overlap_unit u_top (.*);

  always #5 clk_i = ~clk_i;

  // predictor copy of the register file
  logic [30:0] bw_q [2];
  logic [31:0] inv_q [2];
  logic signed [31:0] org_q [2];
  logic [15:0] nb_q [2];

  overlap_word_t expected_words[$];
  int  errors = 0;
  bit  idle_free = 1'b0;   // stretch without random idling
  int  got_words = 0;

  function automatic longint est_index(longint d, logic [31:0] inv);
    logic [63:0] m;
    logic [63:0] r;
    m = d < 0 ? -d : d;
    r = (m >> 32) * {32'd0, inv} + (((m & 64'hFFFF_FFFF) * {32'd0, inv}) >> 32);
    return d < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint snap_edge(longint idx, longint pos, longint org, longint bw);
    if (org + idx * bw > pos) idx--;
    if (org + (idx + 1) * bw <= pos) idx++;
    return idx;
  endfunction

  // work out the overlap words of one axis and push them
  task automatic predict_axis(int a, logic [31:0] c, logic [31:0] s, bit y_last);
    longint bw, nb, org, lo, hi, eps, l, r, w, bl, br, lft, rgt, d;
    overlap_word_t wd;
    bw = bw_q[a];
    nb = nb_q[a] == 0 ? 1 : nb_q[a];
    org = org_q[a];
    lo = longint'($signed(c)) - (longint'($signed(s)) >>> 1);
    hi = lo + longint'($signed(s));
    eps = (bw + 5000) / 10000;
    if (eps < 1) eps = 1;
    l = clampl(est_index(lo - org, inv_q[a]), 0, nb - 1);
    l = clampl(snap_edge(l, lo, org, bw), 0, nb - 1);
    r = clampl(est_index(hi - org, inv_q[a]), 0, nb - 1);
    r = snap_edge(r, hi - eps, org, bw);
    if (r < l) r = l;
    if (r > nb - 1) r = nb - 1;
    w = r - l + 1;
    if (w > MAX_BINS) w = MAX_BINS;
    for (longint j = 0; j < w; j++) begin
      bl = org + (l + j) * bw;
      br = bl + bw;
      lft = lo > bl ? lo : bl;
      rgt = hi < br ? hi : br;
      d = rgt - lft;
      if (d < 0) d = 0;
      if (d > 64'h7FFF_FFFF) d = 64'h7FFF_FFFF;
      wd.axis = a[0];
      wd.run_pos = j[2:0];
      wd.bin_idx = 16'(l + j);
      wd.overlap = d[30:0];
      wd.last = y_last && (j == w - 1);
      expected_words.push_back(wd);
    end
  endtask

  task automatic predict_cell(logic [31:0] cx, cy, sx, sy);
    if ($signed(sx) <= 0 || $signed(sy) <= 0) return;
    predict_axis(0, cx, sx, 1'b0);
    predict_axis(1, cy, sy, 1'b1);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_BIN_WIDTH:  bw_q[0] = val[30:0];
      REG_BIN_HEIGHT: bw_q[1] = val[30:0];
      REG_INV_WIDTH:  inv_q[0] = val;
      REG_INV_HEIGHT: inv_q[1] = val;
      REG_ORIGIN_X:   org_q[0] = val;
      REG_ORIGIN_Y:   org_q[1] = val;
      REG_BINS_X:     nb_q[0] = val[15:0];
      REG_BINS_Y:     nb_q[1] = val[15:0];
      default: ;
    endcase
  endtask

  // bin grid of a given size along both axes, with a matching reciprocal
  task automatic set_grid(logic [30:0] bw, logic signed [31:0] ox, logic signed [31:0] oy,
                          logic [15:0] nx, logic [15:0] ny);
    logic [31:0] inv;
    inv = bw == 0 ? 32'hFFFF_FFFF : 32'((64'd1 << 32) / bw);
    write_reg(REG_BIN_WIDTH, {1'b0, bw});
    write_reg(REG_BIN_HEIGHT, {1'b0, bw});
    write_reg(REG_INV_WIDTH, inv);
    write_reg(REG_INV_HEIGHT, inv);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_BINS_X, nx);
    write_reg(REG_BINS_Y, ny);
  endtask

  // present one cell word and hold it until accepted; valid drops only while idling
  task automatic send_cell(logic [31:0] cx, cy, sx, sy);
    while (!idle_free && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    center_x_i <= cx;
    center_y_i <= cy;
    size_x_i <= sx;
    size_y_i <= sy;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_cell(cx, cy, sx, sy);
    @(negedge clk_i);
  endtask

  // wait until the pipe has drained, then let the latency pass
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  // receiver stall, changed at the falling edge
  always @(negedge clk_i)
    out_stall_i <= !idle_free && ($urandom_range(99) < 30);

  // compare each accepted word with the oldest expectation
  always @(posedge clk_i) begin
    overlap_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_words++;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word axis=%0d pos=%0d bin=%0d ov=%0h last=%0d", $time,
                 axis_o, run_position_o, bin_index_o, overlap_o, last_result_o);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (e.axis !== axis_o || e.run_pos !== run_position_o || e.bin_idx !== bin_index_o ||
            e.overlap !== overlap_o || e.last !== last_result_o) begin
          $display("%0t: mismatch expected axis=%0d pos=%0d bin=%0d ov=%0h last=%0d", $time,
                   e.axis, e.run_pos, e.bin_idx, e.overlap, e.last);
          $display("%0t:          actual   axis=%0d pos=%0d bin=%0d ov=%0h last=%0d", $time,
                   axis_o, run_position_o, bin_index_o, overlap_o, last_result_o);
          errors++;
        end
      end
    end
  end

  // random cell: mostly near the grid, sometimes any bit pattern
  task automatic random_cell(longint span);
    logic [31:0] cx, cy, sx, sy;
    if ($urandom_range(9) == 0) begin
      cx = $urandom; cy = $urandom; sx = $urandom; sy = $urandom;
    end else begin
      cx = 32'(longint'(org_q[0]) + longint'($urandom_range(32'(span))) - span / 8);
      cy = 32'(longint'(org_q[1]) + longint'($urandom_range(32'(span))) - span / 8);
      sx = 32'($urandom_range(32'(bw_q[0] * 3 < 32'h7fff_ffff ? bw_q[0] * 3 : 32'h7fff_ffff)));
      sy = 32'($urandom_range(32'(bw_q[1] * 3 < 32'h7fff_ffff ? bw_q[1] * 3 : 32'h7fff_ffff)));
      if ($urandom_range(19) == 0) sx = -sx;
    end
    send_cell(cx, cy, sx, sy);
  endtask

  cell_row_t directed[] = '{
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 0},   // zero width skipped
    '{32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h8000_0000, 0},   // negative height
    '{32'h0002_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 2},   // one bin each axis
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -1},  // top extremes
    '{32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'h0000_0001, 2},   // far below grid
    '{32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16},  // capped runs
    '{32'h0003_E800, 32'h0003_E800, 32'h0003_E800, 32'h0003_E800, -1},  // bin edge alignment
    '{32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, -1},
    '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0012_3456, 32'h0765_4321, -1},
    '{32'hAAAA_AAAA, 32'h5555_5555, 32'h0FED_CBA9, 32'h0000_FFFF, -1}
  };

  initial begin
    int before_n;
    bw_q = '{31'd256000, 31'd256000};
    inv_q = '{32'd16777, 32'd16777};
    org_q = '{32'sd0, 32'sd0};
    nb_q = '{16'd512, 16'd512};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table at reset settings
    foreach (directed[i]) begin
      before_n = expected_words.size();
      send_cell(directed[i].cx, directed[i].cy, directed[i].sx, directed[i].sy);
      if (directed[i].n_known >= 0 && expected_words.size() - before_n != directed[i].n_known)
      begin
        $display("%0t: row %0d expected %0d words, predicted %0d", $time, i,
                 directed[i].n_known, expected_words.size() - before_n);
        errors++;
      end
    end
    drain();

    // zero bin count and zero bin size, then maximum bin size and bin count with extreme reciprocals
    set_grid(31'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'd0, 16'd0);
    for (int i = 0; i < 8; i++) random_cell(64'hFFFF_FFFF);
    drain();
    set_grid(31'h7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 16'hFFFF, 16'hFFFF);
    write_reg(REG_INV_WIDTH, 32'd0);
    write_reg(REG_INV_HEIGHT, 32'hFFFF_FFFF);
    for (int i = 0; i < 8; i++) random_cell(64'hFFFF_FFFF);
    drain();

    // random phases over several grids
    for (int ph = 0; ph < 5; ph++) begin
      logic [30:0] bw;
      bw = ph == 0 ? 31'd1 : 31'($urandom_range(32'h0100_0000, 32'h0000_4000));
      set_grid(bw, $urandom_range(32'h0010_0000) - 32'h0008_0000,
               $urandom_range(32'h0010_0000) - 32'h0008_0000,
               16'($urandom_range(64, 1)), 16'($urandom_range(64, 1)));
      if (ph == 4) write_reg(REG_INV_WIDTH, inv_q[0] + $urandom_range(3) - 1);
      idle_free = (ph == 2);
      for (int i = 0; i < 50; i++) begin
        random_cell(longint'(bw) * longint'(nb_q[0] > nb_q[1] ? nb_q[0] : nb_q[1]) * 5 / 4);
        // sender holds off until the pipe is empty
        if (i == 25) begin
          in_valid_i <= 1'b0;
          @(negedge clk_i);
          while (expected_words.size() != 0) @(negedge clk_i);
        end
      end
      idle_free = 1'b0;
      drain();
    end

    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[cell_bin_overlap_unit.f]
+incdir+rtl
rtl/cbo_pkg.sv
rtl/cbo_axis.sv
rtl/cbo_emit.sv
rtl/cell_bin_overlap_unit.sv
tb/sv/cell_bin_overlap_unit_tb.sv
